>>> rtl/core/key_sorter_defines.svh
// Assertion macros for the key sorter.
`ifndef KEY_SORTER_DEFINES_SVH
`define KEY_SORTER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define KS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define KS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ks_pkg.sv
package ks_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SORT_DESC   = 8'd0,
    REG_KEYS_SIGNED = 8'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2
  } sel_e;

  typedef struct packed {
    sel_e sel;
    logic desc;
    logic sgn;
  } ks_ctrl_t;

endpackage

>>> rtl/core/ks_if.sv
interface ks_in_if;
  logic                    valid;
  logic                    ready;
  logic [ks_pkg::KEY_W-1:0] key_in;
  logic                    last_in;

  modport source (output valid, key_in, last_in, input ready);
  modport sink   (input valid, key_in, last_in, output ready);
endinterface

interface ks_out_if;
  logic                    valid;
  logic                    ready;
  logic [ks_pkg::KEY_W-1:0] key_out;
  logic                    last_out;

  modport source (output valid, key_out, last_out, input ready);
  modport sink   (input valid, key_out, last_out, output ready);
endinterface

interface ks_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ks_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [ks_pkg::CFG_DATA_W-1:0] reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

>>> rtl/core/ks_cell.sv
module ks_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ks_pkg::ks_ctrl_t    ctrl_i,
  input  logic                left_valid_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic                right_valid_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  output logic                valid_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic                gt_o
);

  localparam logic [KEY_BITS-1:0] SignMask = KEY_BITS'(1) << (KEY_BITS - 1);

  logic                valid_q, valid_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] own_ord, right_ord;

  always_comb begin
    own_ord   = key_q ^ (ctrl_i.sgn ? SignMask : '0);
    right_ord = right_key_i ^ (ctrl_i.sgn ? SignMask : '0);
    if (ctrl_i.desc) begin
      own_ord   = ~own_ord;
      right_ord = ~right_ord;
    end
  end

  // An empty cell orders after every key.
  assign gt_o = right_valid_i && (!valid_q || (own_ord > right_ord));

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    unique case (ctrl_i.sel)
      ks_pkg::SEL_HOLD: begin
      end
      ks_pkg::SEL_LEFT: begin
        valid_d = left_valid_i;
        key_d   = left_key_i;
      end
      ks_pkg::SEL_RIGHT: begin
        valid_d = right_valid_i;
        key_d   = right_key_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;

endmodule

>>> rtl/core/key_sorter.sv
// Key sorter: collects a set of up to MAX_KEYS keys and returns them sorted.
// in_i takes one key word per cycle while the block is filling; last_in ends
// the set, and so does the word that fills the last free cell.
// cfg_i writes sort_descending (index 0) and keys_signed (index 1), bit 0 of
// the data; other indexes are dropped. cfg_i is always ready.
// Keys sit in a row of MAX_KEYS cells. After the set closes, the row runs
// MAX_KEYS odd-even exchange passes, one per cycle, then shifts the sorted
// keys out of cell 0 on out_o, one word per cycle while out_o.ready is high.
// The pass count of the exchange row sets the sorting time.
// in_i.ready is low from the closing word until the last result is taken.
// When the receiver stalls, the head key holds in cell 0 and the row holds.
// Reset empties all cells, selects ascending unsigned order and opens a new set.
module key_sorter #(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ks_in_if.sink        in_i,
  ks_out_if.source     out_o,
  ks_cfg_if.sink       cfg_i
);

  `include "key_sorter_defines.svh"

  localparam int unsigned CntW = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;

  typedef enum logic [2:0] {
    ST_FILL  = 3'b001,
    ST_SORT  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] pass_q, pass_d;
  logic desc_q, sgn_q;

  logic                cell_valid [MAX_KEYS];
  logic [KEY_BITS-1:0] cell_key   [MAX_KEYS];
  logic [MAX_KEYS-1:0] gt;
  logic [MAX_KEYS-1:0] act;
  ks_pkg::ks_ctrl_t    ctrl [MAX_KEYS];

  logic in_acc, out_acc, closing;

  assign in_i.ready  = (state_q == ST_FILL);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_o.valid && out_o.ready;
  assign closing     = in_acc && (in_i.last_in || (cnt_q == CntW'(MAX_KEYS - 1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
      sgn_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        ks_pkg::REG_SORT_DESC:   desc_q <= cfg_i.reg_data[0];
        ks_pkg::REG_KEYS_SIGNED: sgn_q  <= cfg_i.reg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_FILL: begin
        if (closing) begin
          state_d = ST_SORT;
          cnt_d   = '0;
          pass_d  = '0;
        end else if (in_acc) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SORT: begin
        pass_d = pass_q + 1'b1;
        if (pass_q == CntW'(MAX_KEYS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_o.last_out) begin
          state_d = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      cnt_q   <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
    end
  end

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    logic                lv, rv;
    logic [KEY_BITS-1:0] lk, rk;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lk = in_i.key_in[KEY_BITS-1:0];
    end else begin : g_body
      assign lv = cell_valid[i-1];
      assign lk = cell_key[i-1];
    end

    if (i == MAX_KEYS - 1) begin : g_tail
      assign rv     = 1'b0;
      assign rk     = '0;
      assign act[i] = 1'b0;
    end else begin : g_pair
      assign rv     = cell_valid[i+1];
      assign rk     = cell_key[i+1];
      assign act[i] = gt[i] && (state_q == ST_SORT) && (pass_q[0] == 1'(i % 2));
    end

    always_comb begin
      ctrl[i].desc = desc_q;
      ctrl[i].sgn  = sgn_q;
      ctrl[i].sel  = ks_pkg::SEL_HOLD;
      if (in_acc) begin
        ctrl[i].sel = ks_pkg::SEL_LEFT;
      end else if (out_acc || act[i]) begin
        ctrl[i].sel = ks_pkg::SEL_RIGHT;
      end else if ((i > 0) && act[(i > 0) ? i - 1 : 0]) begin
        ctrl[i].sel = ks_pkg::SEL_LEFT;
      end
    end

    ks_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl[i]),
      .left_valid_i  (lv),
      .left_key_i    (lk),
      .right_valid_i (rv),
      .right_key_i   (rk),
      .valid_o       (cell_valid[i]),
      .key_o         (cell_key[i]),
      .gt_o          (gt[i])
    );
  end

  assign out_o.valid    = (state_q == ST_DRAIN) && cell_valid[0];
  assign out_o.key_out  = ks_pkg::KEY_W'(cell_key[0]);
  assign out_o.last_out = !cell_valid[1];

  `KS_ASSERT_SAME(a_out_only_drain, out_o.valid, state_q == ST_DRAIN,
                  "result offered outside drain")
  `KS_ASSERT_NEXT(a_close_sorts, closing, state_q == ST_SORT && !in_i.ready,
                  "closing word did not start the sort")
  `KS_ASSERT_NEXT(a_sort_ends_nonempty, state_q == ST_SORT && pass_q == CntW'(MAX_KEYS - 1),
                  state_q == ST_DRAIN && out_o.valid, "sorted set is empty")
  `KS_ASSERT_NEXT(a_last_empties, out_acc && out_o.last_out,
                  state_q == ST_FILL && !cell_valid[0], "row not empty after last word")

endmodule
